[src/sktbl_pkg.sv]
// ----------------------------------------------------------------------------
// sktbl_pkg
// Shared types and codes for the sorted key/value table.
// ----------------------------------------------------------------------------
package sktbl_pkg;

  typedef enum logic [1:0] {
    KIND_INSERT = 2'd0,
    KIND_LOOKUP = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_SPARE  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_NEW    = 2'd0,
    ST_FOUND  = 2'd1,
    ST_ABSENT = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD
  } state_t;

  typedef struct packed {
    logic load;
    logic compare;
    logic commit;
  } cmd_t;

endpackage

[src/sktbl_ctrl.sv]
// ----------------------------------------------------------------------------
// sktbl_ctrl
// Request sequencer: accept, compare, then commit into the output register.
// ----------------------------------------------------------------------------
module sktbl_ctrl import sktbl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output cmd_t cmd
);

  state_t state;
  state_t state_next;
  logic   out_valid_next;
  logic   can_commit;

  assign can_commit = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_CMP;
      end
      S_CMP: begin
        state_next = S_UPD;
      end
      S_UPD: begin
        if (can_commit) state_next = in_valid ? S_CMP : S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        in_stall = 1'b0;
      end
      S_CMP: begin
        cmd.compare = 1'b1;
      end
      S_UPD: begin
        cmd.commit = can_commit;
        in_stall   = !can_commit;
      end
      default: ;
    endcase
    cmd.load = in_valid && !in_stall;
  end

  assign out_valid_next = cmd.commit || (out_valid && out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

[src/sktbl_dp.sv]
// ----------------------------------------------------------------------------
// sktbl_dp
// Chain of key/value cells with parallel compare, shift and result register.
// ----------------------------------------------------------------------------
module sktbl_dp import sktbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic [1:0]         kind,
  input  logic signed [31:0] req_key,
  input  logic signed [31:0] req_value,
  output logic [1:0]         status,
  output logic signed [31:0] old_value,
  output logic [4:0]         entry_count,
  output logic               is_empty
);

  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic                order_descending;
  logic [CW-1:0]       count;
  logic [CW-1:0]       count_next;
  kind_t               req_kind;
  logic signed [31:0]  req_key_q;
  logic signed [31:0]  req_value_q;
  logic signed [31:0]  cell_key [CAPACITY];
  logic signed [31:0]  cell_value [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic [CAPACITY-1:0] goes_first;
  logic [CAPACITY-1:0] match_q;
  logic [CAPACITY-1:0] goes_first_q;
  logic [CAPACITY-1:0] at_or_after;
  logic [CAPACITY-1:0] past_match;
  logic                hit;
  logic                full;
  logic signed [31:0]  found_value;
  status_t             status_next;
  logic                do_update;
  logic                do_insert;
  logic                do_remove;

  // compare stage
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      match[i]      = (CW'(i) < count) && (cell_key[i] == req_key_q);
      goes_first[i] = (CW'(i) < count) &&
                      (order_descending ? (req_key_q > cell_key[i])
                                        : (req_key_q < cell_key[i]));
    end
  end

  // update stage
  always_comb begin
    at_or_after[0] = goes_first_q[0] || (count == '0);
    past_match[0]  = match_q[0];
    found_value    = match_q[0] ? cell_value[0] : '0;
    for (int i = 1; i < CAPACITY; i++) begin
      at_or_after[i] = at_or_after[i-1] || goes_first_q[i] || (CW'(i) >= count);
      past_match[i]  = past_match[i-1] || match_q[i];
      found_value    = found_value | (match_q[i] ? cell_value[i] : '0);
    end
  end

  assign hit  = |match_q;
  assign full = (count == CAP_C);

  always_comb begin
    do_update   = 1'b0;
    do_insert   = 1'b0;
    do_remove   = 1'b0;
    count_next  = count;
    status_next = hit ? ST_FOUND : ST_ABSENT;
    unique case (req_kind)
      KIND_INSERT: begin
        if (hit) begin
          do_update = 1'b1;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          do_insert   = 1'b1;
          count_next  = count + 1'b1;
          status_next = ST_NEW;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          do_remove  = 1'b1;
          count_next = count - 1'b1;
        end
      end
      KIND_LOOKUP, KIND_SPARE: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_kind    <= kind_t'(kind);
      req_key_q   <= req_key;
      req_value_q <= req_value;
    end
    if (cmd.compare) begin
      match_q      <= match;
      goes_first_q <= goes_first;
    end
    if (cmd.commit) begin
      status      <= status_next;
      old_value   <= hit ? found_value : '0;
      entry_count <= 5'(count_next);
      is_empty    <= (count_next == '0);
    end
  end

  // cell chain
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (do_update && match_q[i]) begin
          cell_value[i] <= req_value_q;
        end else if (do_insert) begin
          if (i == 0) begin
            if (at_or_after[0]) begin
              cell_key[0]   <= req_key_q;
              cell_value[0] <= req_value_q;
            end
          end else if (at_or_after[i-1]) begin
            cell_key[i]   <= cell_key[i-1];
            cell_value[i] <= cell_value[i-1];
          end else if (at_or_after[i]) begin
            cell_key[i]   <= req_key_q;
            cell_value[i] <= req_value_q;
          end
        end else if (do_remove && i < CAPACITY - 1) begin
          if (past_match[i]) begin
            cell_key[i]   <= cell_key[i+1];
            cell_value[i] <= cell_value[i+1];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count            <= '0;
      order_descending <= 1'b0;
    end else begin
      if (cmd.commit) count <= count_next;
      if (cfg_we) order_descending <= cfg_wdata;
    end
  end

endmodule

[src/sorted_key_value_table_core.sv]
// ----------------------------------------------------------------------------
// sorted_key_value_table_core
// Bounded table of unique key/value pairs kept sorted by key.
// ----------------------------------------------------------------------------
// Each request passes through a compare state, which checks the key against
// every stored cell in parallel, then an update state, which shifts or
// updates the cell chain and loads the result register. A new request is
// taken in the commit cycle, overlapping the last one, while results are
// drained. The order bit applies to inserts made after it is written.
module sorted_key_value_table_core import sktbl_pkg::*; #(
  parameter int CAPACITY = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_wdata,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         kind,
  input  logic signed [31:0] req_key,
  input  logic signed [31:0] req_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         status,
  output logic signed [31:0] old_value,
  output logic [4:0]         entry_count,
  output logic               is_empty
);

  cmd_t cmd;

  sktbl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  sktbl_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .kind        (kind),
    .req_key     (req_key),
    .req_value   (req_value),
    .status      (status),
    .old_value   (old_value),
    .entry_count (entry_count),
    .is_empty    (is_empty)
  );

endmodule

[src/sktbl_checker.sv]
// ----------------------------------------------------------------------------
// sktbl_checker
// Port-level checks for the sorted key/value table.
// ----------------------------------------------------------------------------
module sktbl_checker import sktbl_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [1:0]         status,
  input logic signed [31:0] old_value,
  input logic [4:0]         entry_count,
  input logic               is_empty
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result shown right after reset");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_empty |-> entry_count == 5'd0)
    else $error("empty flag with nonzero count");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_ABSENT || status == ST_FULL) |-> old_value == 32'sd0)
    else $error("nonzero old value on miss");

endmodule

bind sorted_key_value_table_core sktbl_checker u_chk (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .status      (status),
  .old_value   (old_value),
  .entry_count (entry_count),
  .is_empty    (is_empty)
);
